@@ design/xdz_pkg.sv @@
// Shared types and constants for the XOR-delta zero run-length encoder.
// No dependencies; every module of the block imports this package.
`default_nettype none

package xdz_pkg;

    localparam int CNT_W            = 14;
    localparam int MAX_IMAGE_BYTES_D = 8192;
    localparam int QDEPTH           = 2;
    localparam int QPTR_W           = $clog2(QDEPTH);

    localparam logic KIND_LITERAL = 1'b0;
    localparam logic KIND_RUN     = 1'b1;

    typedef struct packed {
        logic [7:0] cur_byte;
        logic [7:0] orig_byte;
        logic       has_orig;
        logic       end_of_image;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last_of_run;
    } out_item_t;

    // One flush job: the zero run ahead of a literal, and the literal itself.
    typedef struct packed {
        logic [CNT_W-1:0] run_count;
        logic [7:0]       diff;
    } q_entry_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

@@ design/xdz_front.sv @@
// Front end: accepts items, forms the XOR difference and counts zero runs.
// Pushes one flush job per nonzero difference. Depends on xdz_pkg.
`default_nettype none

module xdz_front
    import xdz_pkg::*;
#(
    parameter int MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_D
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    input  wire q_status_t q_stat,
    output logic           q_push,
    output q_entry_t       q_wdata
);

    localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_IMAGE_BYTES);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       diff;
    logic             accept;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign diff     = in_data.has_orig ? (in_data.cur_byte ^ in_data.orig_byte)
                                       : in_data.cur_byte;
    assign q_push   = accept && (diff != 8'd0);
    assign q_wdata  = '{run_count: count_reg, diff: diff};

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (diff != 8'd0)
                count_next = '0;
            else if (count_reg < MaxCnt)
                count_next = count_reg + CNT_W'(1);
            // drop the trailing run at the image end
            if (in_data.end_of_image)
                count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

`default_nettype wire

@@ design/xdz_queue.sv @@
// Short register queue of flush jobs between front and back.
// Depends on xdz_pkg.
`default_nettype none

module xdz_queue
    import xdz_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t wdata,
    input  wire logic     pop,
    output q_entry_t      rdata,
    output q_status_t     stat
);

    q_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    assign rdata          = mem_reg[rptr_reg];
    assign stat.not_empty = (fill_reg != '0);
    assign stat.full      = (fill_reg == (QPTR_W+1)'(QDEPTH));

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (push)
            wptr_next = (wptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : wptr_reg + QPTR_W'(1);
        if (pop)
            rptr_next = (rptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : rptr_reg + QPTR_W'(1);
        if (push && !pop)
            fill_next = fill_reg + (QPTR_W+1)'(1);
        else if (pop && !push)
            fill_next = fill_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

@@ design/xdz_back.sv @@
// Back end: turns each flush job into run records of at most 256 zeros
// and a closing literal, through a registered output stage. Depends on xdz_pkg.
`default_nettype none

module xdz_back
    import xdz_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_status_t q_stat,
    input  wire q_entry_t  q_rdata,
    output logic           q_pop,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [7:0]       diff_reg, diff_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic             out_free, work, full_rec;
    logic [CNT_W-1:0] cur_rem;
    logic [7:0]       cur_diff;

    assign out_free = !out_valid_reg || !out_stall;
    assign work     = busy_reg || q_stat.not_empty;
    // take the job straight from the queue head when idle
    assign cur_rem  = busy_reg ? rem_reg : q_rdata.run_count;
    assign cur_diff = busy_reg ? diff_reg : q_rdata.diff;
    assign full_rec = (cur_rem[CNT_W-1:8] != '0);
    assign q_pop    = out_free && !busy_reg && q_stat.not_empty;

    always_comb
    begin
        busy_next      = busy_reg;
        rem_next       = rem_reg;
        diff_next      = diff_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (out_free && work)
        begin
            out_valid_next = 1'b1;
            diff_next      = cur_diff;
            if (cur_rem != '0)
            begin
                busy_next = 1'b1;
                if (full_rec)
                begin
                    out_data_next = '{kind: KIND_RUN, value: 8'hFF, last_of_run: 1'b0};
                    rem_next      = cur_rem - CNT_W'(256);
                end
                else
                begin
                    out_data_next = '{kind: KIND_RUN, value: cur_rem[7:0] - 8'd1,
                                      last_of_run: 1'b0};
                    rem_next      = '0;
                end
            end
            else
            begin
                busy_next     = 1'b0;
                out_data_next = '{kind: KIND_LITERAL, value: cur_diff, last_of_run: 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        diff_reg     <= diff_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ design/xor_delta_zero_rle_encoder_top.sv @@
// XOR-delta zero run-length encoder, top level.
// Instantiates xdz_front, xdz_queue and xdz_back; depends on xdz_pkg.
//
// Input channel (in_valid / in_stall / in_data): one memory byte per item with
// its original byte, a has_orig flag and an end_of_image flag.
// Output channel (out_valid / out_stall / out_data): results of kind run record
// (value = zeros minus one, at most 256 zeros each) or literal (nonzero XOR
// difference, last_of_run set). Each nonzero difference yields its run records
// then its literal; a zero difference yields nothing.
// Throughput: the front takes one item per cycle while the queue has room; a
// literal after L zeros yields ceil(L/256) run records then the literal, one
// result per cycle while the receiver does not stall, set by the single output
// register. An accepted item reaches its first result via the queue write,
// then the output register. The front stalls only while the two-entry job
// queue is full. When the receiver stalls, the output register holds its item
// and the back end halts; the front keeps taking items until the queue fills.
// Reset clears the zero-run counter, the queue and the output valid.
`default_nettype none

module xor_delta_zero_rle_encoder_top
    import xdz_pkg::*;
#(
    parameter int MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_D
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_data
);

    q_status_t q_stat;
    q_entry_t  q_wdata, q_rdata;
    logic      q_push, q_pop;

    xdz_front #(
        .MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data (in_data),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    xdz_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .wdata(q_wdata),
        .pop  (q_pop),
        .rdata(q_rdata),
        .stat (q_stat)
    );

    xdz_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

@@ design/xdz_checker.sv @@
// Port-level checks for the encoder top level, attached by bind.
// Depends on xdz_pkg.
`default_nettype none

module xdz_port_checks
    import xdz_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_item_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_data
);

    // a stalled input item stays offered and unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled input item dropped or changed");

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output item dropped or changed");

    a_run_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_RUN |-> !out_data.last_of_run)
        else $error("run record flagged last");

    a_literal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_LITERAL
            |-> out_data.last_of_run && out_data.value != 8'd0)
        else $error("bad literal item");

    // a short run record closes the run: the literal must follow
    a_short_run_then_literal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.kind == KIND_RUN && out_data.value != 8'hFF
            |=> !out_valid || out_data.kind == KIND_LITERAL)
        else $error("run record after a partial run record");

endmodule

bind xor_delta_zero_rle_encoder_top xdz_port_checks u_xdz_port_checks (.*);

`default_nettype wire
